/* rtl/core/dpwp_pkg.sv */
// ----------------------------------------------------------------------------
// Depth pixel to world point: shared package
// Action codes, configuration register indexes, queue entry type and the
// fixed-point saturation helper; imported by the front and back sections.
// ----------------------------------------------------------------------------
package dpwp_pkg;

  typedef enum logic [1:0] {
    ACT_PIXEL  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_COMMIT = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam logic [2:0] CFG_IFX = 3'd0;
  localparam logic [2:0] CFG_IFY = 3'd1;
  localparam logic [2:0] CFG_CX  = 3'd2;
  localparam logic [2:0] CFG_CY  = 3'd3;
  localparam logic [2:0] CFG_IDS = 3'd4;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // Kinds of work that the front hands to the back.
  typedef enum logic [1:0] {
    JOB_PIXEL  = 2'd0,
    JOB_COMMIT = 2'd1,
    JOB_LOAD   = 2'd2
  } job_e;

  typedef struct packed {
    job_e        job;
    logic [12:0] u;
    logic [12:0] v;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [2:0]  pose_index;
    logic [31:0] pose_value;
  } job_t;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fff_ffff;
    else if (x < -66'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/dpwp_front.sv */
// ----------------------------------------------------------------------------
// Depth pixel to world point: front section
// Accepts requests, drops zero-depth pixels, loads to pose index 7 and unused
// codes, and pushes the rest into a short queue toward the back section.
// ----------------------------------------------------------------------------
module dpwp_front #(
  parameter int COORD_BITS = 10,
  parameter int DEPTH_LOG2 = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [COORD_BITS-1:0] column_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [15:0]          depth_i,
  input  logic [7:0]           blue_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           red_i,
  input  logic [2:0]           pose_index_i,
  input  logic [31:0]          pose_value_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output dpwp_pkg::job_t       q_job_o
);
  import dpwp_pkg::*;

  localparam int Depth = 1 << DEPTH_LOG2;

  job_t                 mem_q [Depth];
  logic [DEPTH_LOG2:0]  wr_q, wr_d, rd_q, rd_d;
  logic [DEPTH_LOG2:0]  fill;
  logic                 accept, push;
  job_t                 job;

  assign fill       = wr_q - rd_q;
  assign in_stall_o = (fill == (DEPTH_LOG2+1)'(Depth));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    job            = '0;
    job.u          = 13'(column_i);
    job.v          = 13'(row_i);
    job.depth      = depth_i;
    job.blue       = blue_i;
    job.green      = green_i;
    job.red        = red_i;
    job.pose_index = pose_index_i;
    job.pose_value = pose_value_i;
    push           = 1'b0;
    unique case (action_e'(action_i))
      ACT_PIXEL: begin
        job.job = JOB_PIXEL;
        push    = (depth_i != 16'd0);
      end
      ACT_LOAD: begin
        job.job = JOB_LOAD;
        push    = (pose_index_i != 3'd7);
      end
      ACT_COMMIT: begin
        job.job = JOB_COMMIT;
        push    = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign wr_d = wr_q + (DEPTH_LOG2+1)'(accept && push);
  assign rd_d = rd_q + (DEPTH_LOG2+1)'(q_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push) mem_q[wr_q[DEPTH_LOG2-1:0]] <= job;
  end

  assign q_valid_o = (fill != '0);
  assign q_job_o   = mem_q[rd_q[DEPTH_LOG2-1:0]];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= (DEPTH_LOG2+1)'(Depth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill == (DEPTH_LOG2+1)'(Depth)) |-> !accept) else $error("accept when full");
endmodule

/* rtl/core/dpwp_back.sv */
// ----------------------------------------------------------------------------
// Depth pixel to world point: back section
// Keeps the pose words and the 3x4 transform, builds the rotation on a commit
// and runs pixels through a five-stage multiply pipeline to the output.
// ----------------------------------------------------------------------------
module dpwp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  dpwp_pkg::job_t       q_job_i,
  input  logic [23:0]          ifx_i,
  input  logic [23:0]          ify_i,
  input  logic [15:0]          cx_i,
  input  logic [15:0]          cy_i,
  input  logic [23:0]          ids_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   point_x_o,
  output logic signed [31:0]   point_y_o,
  output logic signed [31:0]   point_z_o,
  output logic [7:0]           out_blue_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_red_o
);
  import dpwp_pkg::*;

  // Pipeline advances whenever the output slot is free or being taken.
  logic adv;
  logic [4:0] v_q;
  logic busy;
  assign adv = !(out_valid_o && out_stall_i);

  // A commit or load waits until no pixel is in flight, so pixels ahead of it
  // see the old transform. Anything behind a commit also waits for its product stage.
  logic cm_q;
  assign busy = (v_q[3:0] != 4'd0) || cm_q;
  logic is_pix;
  assign is_pix = (q_job_i.job == JOB_PIXEL);
  assign q_pop_o = q_valid_i && adv && (is_pix ? !cm_q : !busy);

  logic signed [31:0] pw_q [7];
  logic signed [31:0] tm_q [12];

  // Commit stage one: registered rounded quaternion products.
  logic signed [33:0] pr_q [10];
  function automatic logic signed [33:0] qp(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
    logic signed [63:0] m;
    m = a * b + 64'sd536870912;
    return 34'(m >>> 30);
  endfunction
  function automatic logic signed [31:0] rent(input logic signed [33:0] p,
                                              input logic signed [33:0] q,
                                              input logic m1);
    logic signed [65:0] s;
    s = 66'(p) + 66'(q);
    s = s <<< 1;
    if (m1) s = s - 66'sd1073741824;
    return sat32(s);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cm_q <= 1'b0;
    else cm_q <= q_pop_o && (q_job_i.job == JOB_COMMIT);
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_job_i.job == JOB_COMMIT) begin
      pr_q[0] <= qp(pw_q[3], pw_q[3]);
      pr_q[1] <= qp(pw_q[4], pw_q[4]);
      pr_q[2] <= qp(pw_q[5], pw_q[5]);
      pr_q[3] <= qp(pw_q[6], pw_q[6]);
      pr_q[4] <= qp(pw_q[4], pw_q[5]);
      pr_q[5] <= qp(pw_q[4], pw_q[6]);
      pr_q[6] <= qp(pw_q[5], pw_q[6]);
      pr_q[7] <= qp(pw_q[3], pw_q[4]);
      pr_q[8] <= qp(pw_q[3], pw_q[5]);
      pr_q[9] <= qp(pw_q[3], pw_q[6]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) pw_q[i] <= '0;
      for (int i = 0; i < 12; i++)
        tm_q[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q30 : '0;
    end else begin
      if (q_pop_o && q_job_i.job == JOB_LOAD)
        pw_q[q_job_i.pose_index] <= q_job_i.pose_value;
      if (cm_q) begin
        tm_q[0]  <= rent(pr_q[0], pr_q[1], 1'b1);
        tm_q[1]  <= rent(pr_q[4], -pr_q[9], 1'b0);
        tm_q[2]  <= rent(pr_q[5], pr_q[8], 1'b0);
        tm_q[3]  <= pw_q[0];
        tm_q[4]  <= rent(pr_q[4], pr_q[9], 1'b0);
        tm_q[5]  <= rent(pr_q[0], pr_q[2], 1'b1);
        tm_q[6]  <= rent(pr_q[6], -pr_q[7], 1'b0);
        tm_q[7]  <= pw_q[1];
        tm_q[8]  <= rent(pr_q[5], -pr_q[8], 1'b0);
        tm_q[9]  <= rent(pr_q[6], pr_q[7], 1'b0);
        tm_q[10] <= rent(pr_q[0], pr_q[3], 1'b1);
        tm_q[11] <= pw_q[2];
      end
    end
  end

  // Pixel pipeline.
  logic [4:0] v_d;
  assign v_d = {v_q[3:0], q_pop_o && is_pix};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= v_d;
  end
  assign out_valid_o = v_q[4];

  logic [23:0] col_q [5];
  // Stage 0: offsets and ray products.
  logic signed [17:0] du, dv;
  logic signed [33:0] tx0_q, ty0_q, z0_q;
  assign du = $signed({1'b0, q_job_i.u, 4'b0}) - $signed({2'b0, cx_i});
  assign dv = $signed({1'b0, q_job_i.v, 4'b0}) - $signed({2'b0, cy_i});
  logic signed [42:0] mx, my;
  logic [39:0] mz;
  assign mx = du * $signed({1'b0, ifx_i});
  assign my = dv * $signed({1'b0, ify_i});
  assign mz = q_job_i.depth * ids_i;
  // Stage 1: camera x, y.
  logic signed [31:0] c_q [3];
  logic signed [67:0] px, py;
  assign px = tx0_q * z0_q + 68'sd32768;
  assign py = ty0_q * z0_q + 68'sd32768;
  // Stage 2/3: rotation products, then sums; stage 4 holds the output.
  logic signed [33:0] rp_q [9];
  logic signed [31:0] tr_q [3];
  logic signed [31:0] pt_q [3];
  logic signed [31:0] po_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q[0] <= {q_job_i.blue, q_job_i.green, q_job_i.red};
      for (int i = 1; i < 5; i++) col_q[i] <= col_q[i-1];
      tx0_q <= 34'((mx + 43'sd2048) >>> 12);
      ty0_q <= 34'((my + 43'sd2048) >>> 12);
      z0_q  <= 34'((mz + 40'd128) >> 8);
      c_q[0] <= sat32(66'(px >>> 16));
      c_q[1] <= sat32(66'(py >>> 16));
      c_q[2] <= sat32(66'(z0_q));
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++)
          rp_q[r*3+c] <= 34'((tm_q[r*4+c] * c_q[c] + 64'sd536870912) >>> 30);
        tr_q[r] <= tm_q[r*4+3];
      end
      for (int r = 0; r < 3; r++)
        pt_q[r] <= sat32(66'(tr_q[r]) + 66'(rp_q[r*3]) + 66'(rp_q[r*3+1])
                         + 66'(rp_q[r*3+2]));
      for (int r = 0; r < 3; r++) po_q[r] <= pt_q[r];
    end
  end

  assign point_x_o   = po_q[0];
  assign point_y_o   = po_q[1];
  assign point_z_o   = po_q[2];
  assign out_blue_o  = col_q[4][23:16];
  assign out_green_o = col_q[4][15:8];
  assign out_red_o   = col_q[4][7:0];

  a_pose_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !is_pix) |-> (v_q[3:0] == 4'd0)) else $error("pose op with pixel in flight");
  a_commit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cm_q |-> !$past(cm_q)) else $error("back-to-back commit");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q)) else $error("pipeline moved while stalled");
endmodule

/* rtl/core/depth_pixel_to_world_point.sv */
// ----------------------------------------------------------------------------
// Depth pixel to world point: top level
// Pinhole back-projection of depth pixels into the base frame by a stored pose.
// ----------------------------------------------------------------------------
// An accepted pixel passes the queue and then the back pipeline to the output.
// Throughput: one pixel per cycle unless the output stalls; a pose load or
// commit waits for the pixel pipeline to drain, then occupies the back section.
// A four-entry queue between front and back decouples their stalls.
// Reset restores default intrinsics, zero pose words and an identity transform.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [23:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [COORD_BITS-1:0] column_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [15:0]           depth_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            red_i,
  input  logic [2:0]            pose_index_i,
  input  logic signed [31:0]    pose_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    point_x_o,
  output logic signed [31:0]    point_y_o,
  output logic signed [31:0]    point_z_o,
  output logic [7:0]            out_blue_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_red_o
);
  import dpwp_pkg::*;

  logic [23:0] ifx_q, ify_q, ids_q;
  logic [15:0] cx_q, cy_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ifx_q <= 24'd29340;
      ify_q <= 24'd29509;
      cx_q  <= 16'd6988;
      cy_q  <= 16'd4160;
      ids_q <= 24'd16777;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IFX: ifx_q <= cfg_data_i;
        CFG_IFY: ify_q <= cfg_data_i;
        CFG_CX:  cx_q  <= cfg_data_i[15:0];
        CFG_CY:  cy_q  <= cfg_data_i[15:0];
        CFG_IDS: ids_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  q_valid, q_pop;
  job_t  q_job;

  dpwp_front #(.COORD_BITS(COORD_BITS), .DEPTH_LOG2(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .column_i, .row_i,
    .depth_i, .blue_i, .green_i, .red_i, .pose_index_i,
    .pose_value_i(pose_value_i),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_job_o(q_job)
  );

  dpwp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_job_i(q_job),
    .ifx_i(ifx_q), .ify_i(ify_q), .cx_i(cx_q), .cy_i(cy_q), .ids_i(ids_q),
    .out_valid_o, .out_stall_i, .point_x_o, .point_y_o, .point_z_o,
    .out_blue_o, .out_green_o, .out_red_o
  );
endmodule
